/* design/xrd_pkg.sv */
// Package for the xorshift32 range draw block.
// Holds the command type passed from front to back, the state machine type and
// the generator constants. Depends on nothing.
package xrd_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] DEFAULT_SEED = 32'hdeadbabe;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    localparam int unsigned CNT_W = $clog2(DATA_W);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EQUAL,
        OP_DRAW,
        OP_FULL
    } xrd_op_t;

    typedef struct packed {
        xrd_op_t           op;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] span;
    } xrd_cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_ADD,
        B_OUT
    } xrd_back_state_t;

endpackage

/* design/xrd_front.sv */
// Front part of the xorshift32 range draw block.
// Classifies each accepted item, orders the bounds and forms the span.
// Depends on xrd_pkg.
module xrd_front (
    input  logic                     func,
    input  logic [31:0]              range_low,
    input  logic [31:0]              range_high,
    input  logic [31:0]              new_state,
    output xrd_pkg::xrd_cmd_t        cmd
);
    import xrd_pkg::*;

    logic              swap;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] diff;

    always_comb
    begin
        swap = range_low > range_high;
        lo   = swap ? range_high : range_low;
        hi   = swap ? range_low : range_high;
        diff = hi - lo;

        cmd.span = diff + {{(DATA_W-1){1'b0}}, 1'b1};
        if (func)
        begin
            cmd.op   = OP_LOAD;
            cmd.base = new_state;
        end
        else
        begin
            cmd.base = lo;
            if (diff == '0)
            begin
                cmd.op = OP_EQUAL;
            end
            else if (&diff)
            begin
                cmd.op = OP_FULL;
            end
            else
            begin
                cmd.op = OP_DRAW;
            end
        end
    end

endmodule

/* design/xrd_queue.sv */
// Short command queue between the front and back parts.
// A register array with read and write pointers and a fill count.
// Depends on xrd_pkg.
module xrd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_stall,
    input  xrd_pkg::xrd_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_take,
    output xrd_pkg::xrd_cmd_t pop_cmd
);
    import xrd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    xrd_cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_stall = (count_reg == FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_take && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Queue fill count exceeds its depth.");

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("Queue count did not drop after a pop.");

endmodule

/* design/xrd_back.sv */
// Back part of the xorshift32 range draw block.
// Holds the generator state, advances it, runs the radix-2 remainder divider
// and holds the result register. Depends on xrd_pkg.
module xrd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  xrd_pkg::xrd_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [31:0]       value,
    output logic [31:0]       state_out
);
    import xrd_pkg::*;

    xrd_back_state_t   state_reg;
    xrd_back_state_t   state_next;
    xrd_op_t           op_reg;
    xrd_op_t           op_next;
    logic [DATA_W-1:0] gen_reg;
    logic [DATA_W-1:0] gen_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [DATA_W-1:0] base_reg;
    logic [DATA_W-1:0] base_next;
    logic [DATA_W-1:0] span_reg;
    logic [DATA_W-1:0] span_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] dvd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] seed_x;
    logic [DATA_W-1:0] step_a;
    logic [DATA_W-1:0] step_b;
    logic [DATA_W-1:0] advanced;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        seed_x   = (gen_reg == '0) ? DEFAULT_SEED : gen_reg;
        step_a   = seed_x ^ (seed_x << SHIFT_A);
        step_b   = step_a ^ (step_a >> SHIFT_B);
        advanced = step_b ^ (step_b << SHIFT_C);
        trial    = {rem_reg, dvd_reg[DATA_W-1]} - {1'b0, span_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        gen_next   = gen_reg;
        value_next = value_reg;
        base_next  = base_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        cmd_take   = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take  = 1'b1;
                    op_next   = cmd.op;
                    base_next = cmd.base;
                    span_next = cmd.span;
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            gen_next   = cmd.base;
                            value_next = cmd.base;
                            state_next = B_OUT;
                        end
                        OP_EQUAL:
                        begin
                            value_next = cmd.base;
                            state_next = B_OUT;
                        end
                        OP_FULL:
                        begin
                            gen_next   = advanced;
                            value_next = advanced;
                            state_next = B_OUT;
                        end
                        OP_DRAW:
                        begin
                            gen_next   = advanced;
                            dvd_next   = advanced;
                            rem_next   = '0;
                            cnt_next   = '1;
                            state_next = B_DIV;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_DIV:
            begin
                if (trial[DATA_W])
                begin
                    rem_next = {rem_reg[DATA_W-2:0], dvd_reg[DATA_W-1]};
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                end
                dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = B_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            B_ADD:
            begin
                value_next = base_reg + rem_reg;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            gen_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        base_reg  <= base_next;
        span_reg  <= span_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        cnt_reg   <= cnt_next;
    end

    assign value     = value_reg;
    assign state_out = gen_reg;

    a_cnt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV && cnt_reg != '0) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("Divider step count did not advance.");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ADD) |-> (rem_reg < span_reg))
        else $error("Remainder is not below the span.");

    a_draw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (op_reg == OP_DRAW || op_reg == OP_FULL)) |-> (gen_reg != '0))
        else $error("Advanced generator state is zero.");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(value_reg)))
        else $error("Result item changed while stalled.");

endmodule

/* design/xorshift32_range_draw.sv */
// Top level of the xorshift32 range draw block.
// Joins the front classifier, the command queue and the back unit.
// Depends on xrd_pkg, xrd_front, xrd_queue and xrd_back.
//
//  Channel  Handshake             Fields
//  req      req_valid/req_stall   func, range_low, range_high, new_state
//  rsp      rsp_valid/rsp_stall   value, state_out
//
// A draw item passes through the back unit in order: taking the command and
// advancing the state, the radix-2 remainder loop, the final add and presenting
// the result. Load, equal-bound and full-range items skip the loop and the add.
// The queue holds QUEUE_DEPTH items, so requests are taken while the back is busy.
// Reset clears the generator state to zero, the queue and the result valid.
module xorshift32_range_draw #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        func,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    input  logic [31:0] new_state,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] value,
    output logic [31:0] state_out
);
    import xrd_pkg::*;

    xrd_cmd_t front_cmd;
    xrd_cmd_t back_cmd;
    logic     back_valid;
    logic     back_take;

    xrd_front u_front (
        .func       (func),
        .range_low  (range_low),
        .range_high (range_high),
        .new_state  (new_state),
        .cmd        (front_cmd)
    );

    xrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_stall (req_stall),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_take   (back_take),
        .pop_cmd    (back_cmd)
    );

    xrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_take  (back_take),
        .cmd       (back_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value),
        .state_out (state_out)
    );

endmodule

/* verif/tb_xorshift32_range_draw.sv */
`timescale 1ns / 100ps
// Testbench for xorshift32_range_draw: directed and random load and draw items,
// checked against an in-bench xorshift predictor under random sender and receiver idling.
// Depends on xrd_pkg and the xorshift32_range_draw RTL.
module tb_xorshift32_range_draw;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;
    localparam int unsigned N_RANDOM = 1130;
    localparam int unsigned LONG_HOLD_AT = 250;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam time TIMEOUT_NS = 3_600_000;

    typedef struct {
        logic        func;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [31:0] new_state;
        int unsigned gap;
        bit          drain_first;
    } req_item_t;

    typedef struct {
        logic [31:0] value;
        logic [31:0] state;
    } draw_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        func = FUNC_DRAW;
    logic [31:0] range_low = '0;
    logic [31:0] range_high = '0;
    logic [31:0] new_state = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] value;
    logic [31:0] state_out;

    req_item_t    pending_reqs[$];
    draw_result_t expected_draws[$];
    req_item_t    offered;
    logic [31:0]  gen_state;
    int unsigned  wait_cnt;
    int unsigned  stall_left;
    int unsigned  n_results;
    int unsigned  n_errors;
    int unsigned  n_loads;
    int unsigned  n_equal;
    int unsigned  n_full;
    int unsigned  n_ranged;

    xorshift32_range_draw i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .range_low (range_low),
        .range_high(range_high),
        .new_state (new_state),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value),
        .state_out (state_out)
    );

    function automatic draw_result_t predict_draw(input req_item_t it);
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  x;
        logic [32:0]  span;
        logic [32:0]  rem;
        draw_result_t r;
        lo = it.range_low;
        hi = it.range_high;
        if (it.func == FUNC_LOAD)
        begin
            gen_state = it.new_state;
            r.value = it.new_state;
            n_loads++;
        end
        else if (lo == hi)
        begin
            r.value = lo;
            n_equal++;
        end
        else
        begin
            if (lo > hi)
            begin
                lo = it.range_high;
                hi = it.range_low;
            end
            x = (gen_state == '0) ? xrd_pkg::DEFAULT_SEED : gen_state;
            x = x ^ (x << xrd_pkg::SHIFT_A);
            x = x ^ (x >> xrd_pkg::SHIFT_B);
            x = x ^ (x << xrd_pkg::SHIFT_C);
            gen_state = x;
            span = {1'b0, hi} - {1'b0, lo} + 33'd1;
            if (span[32])
            begin
                r.value = x;
                n_full++;
            end
            else
            begin
                rem = {1'b0, x} % span;
                r.value = lo + rem[31:0];
                n_ranged++;
            end
        end
        r.state = gen_state;
        return r;
    endfunction

    task automatic add_item(input logic f, input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] ns, input int unsigned gap,
                            input bit drain_first);
        req_item_t it;
        it.func = f;
        it.range_low = lo;
        it.range_high = hi;
        it.new_state = ns;
        it.gap = gap;
        it.drain_first = drain_first;
        pending_reqs.push_back(it);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Sender: offers the pending items in order and predicts each one as it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            func <= FUNC_DRAW;
            range_low <= '0;
            range_high <= '0;
            new_state <= '0;
            wait_cnt <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_draws.push_back(predict_draw(offered));
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() == 0)
                    req_valid <= 1'b0;
                else if (wait_cnt < pending_reqs[0].gap)
                begin
                    wait_cnt <= wait_cnt + 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs[0].drain_first && expected_draws.size() != 0)
                    req_valid <= 1'b0;
                else
                begin
                    offered = pending_reqs.pop_front();
                    func <= offered.func;
                    range_low <= offered.range_low;
                    range_high <= offered.range_high;
                    new_state <= offered.new_state;
                    req_valid <= 1'b1;
                    wait_cnt <= 0;
                end
            end
        end
    end

    // Receiver: checks each result, then may stall: randomly, not at all, or one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned  hold;
        draw_result_t exp_r;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
            n_results <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %h state %h",
                         $time, value, state_out);
                n_errors++;
            end
            else
            begin
                exp_r = expected_draws.pop_front();
                if (value !== exp_r.value)
                begin
                    $display("%0t: value mismatch, expected %h, got %h",
                             $time, exp_r.value, value);
                    n_errors++;
                end
                if (state_out !== exp_r.state)
                begin
                    $display("%0t: state_out mismatch, expected %h, got %h",
                             $time, exp_r.state, state_out);
                    n_errors++;
                end
            end
            if (n_results == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else if ((n_results % 170) < 30)
                hold = 0;
            else
                hold = $urandom_range(0, 8);
            n_results <= n_results + 1;
            stall_left <= hold;
            rsp_stall <= (hold != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= (stall_left > 1);
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned r;
        int unsigned gap;
        int unsigned waited;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;
        logic [31:0] ns;
        logic        f;

        gen_state = '0;
        n_errors = 0;
        n_loads = 0;
        n_equal = 0;
        n_full = 0;
        n_ranged = 0;

        // Directed items: equal bounds on the reset state, draws from the default seed,
        // zero and all-ones loads, reversed bounds, full and nearly full ranges.
        add_item(FUNC_DRAW, 32'd5, 32'd5, 32'hffffffff, 0, 1'b0);
        add_item(FUNC_DRAW, 32'd0, 32'd9, 32'h0, 0, 1'b0);
        add_item(FUNC_LOAD, 32'h0, 32'h0, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'd0, 32'd0, 32'h12345678, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h0, 32'hffffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_LOAD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 1'b0);
        add_item(FUNC_DRAW, 32'd100, 32'd3, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'hffffffff, 32'hffffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'd0, 32'd1, 32'hffffffff, 0, 1'b0);
        add_item(FUNC_DRAW, 32'hfffffffe, 32'hffffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'hffffffff, 32'h0, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'd1, 32'hffffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h0, 32'hfffffffe, 32'h0, 0, 1'b0);
        add_item(FUNC_LOAD, 32'h0, 32'hffffffff, 32'd1, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h0, 32'h7fffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_LOAD, 32'hffffffff, 32'h0, 32'h80000000, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h80000000, 32'hffffffff, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'hffffffff, 32'h80000000, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h0, 32'h0, 32'h0, 0, 1'b0);
        add_item(FUNC_LOAD, 32'h0, 32'h0, 32'h0, 0, 1'b0);
        add_item(FUNC_DRAW, 32'h1, 32'h0, 32'hffffffff, 0, 1'b0);

        for (i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            gap = ((i % 150) < 25) ? 0 : $urandom_range(0, 8);
            f = FUNC_DRAW;
            ns = $urandom();
            lo = $urandom();
            if (r < 10)
            begin
                f = FUNC_LOAD;
                if ($urandom_range(0, 9) == 0)
                    ns = '0;
                hi = $urandom();
            end
            else if (r < 16)
                hi = lo;
            else if (r < 20)
            begin
                lo = '0;
                hi = 32'hffffffff;
            end
            else if (r < 55)
                hi = lo + $urandom_range(1, 15);
            else if (r < 70)
                hi = lo + ($urandom() >> $urandom_range(0, 31));
            else
                hi = $urandom();
            if ($urandom_range(0, 1) == 1)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            add_item(f, lo, hi, ns, gap, (i == 0) || (i == 400) || (i == 800));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        waited = 0;
        while (expected_draws.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_draws.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_draws.size());
            n_errors++;
        end

        $display("Run covered %0d loads, %0d equal-bound, %0d full-range and %0d ranged draws,",
                 n_loads, n_equal, n_full, n_ranged);
        $display("with %0d results checked and %0d errors.", n_results, n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* xorshift32_range_draw.f */
design/xrd_pkg.sv
design/xrd_front.sv
design/xrd_queue.sv
design/xrd_back.sv
design/xorshift32_range_draw.sv
verif/tb_xorshift32_range_draw.sv
